// ----- hdl/rgtu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgtu_pkg
// Shared types and constants of the race gate timing unit: payload structs,
// event and phase codes, register indexes and the controller interface.
// ----------------------------------------------------------------------------
package rgtu_pkg;

   localparam int TimeW  = 64;
   localparam int SpanW  = 32;
   localparam int TrackW = 16;
   localparam int CsrW   = 32;
   localparam int UsW    = 20;
   localparam int NumW   = TrackW + UsW;
   localparam int DivSteps = NumW;
   localparam int CntW   = $clog2(DivSteps);

   localparam logic [UsW-1:0] US_PER_S = UsW'(1000000);

   // Event codes carried in the mode field.
   localparam logic [2:0] MODE_ARM    = 3'd0;
   localparam logic [2:0] MODE_START  = 3'd1;
   localparam logic [2:0] MODE_OFFSET = 3'd2;
   localparam logic [2:0] MODE_FINISH = 3'd3;
   localparam logic [2:0] MODE_TICK   = 3'd4;

   // Race phases.
   localparam logic [1:0] PHASE_IDLE     = 2'd0;
   localparam logic [1:0] PHASE_ARMED    = 2'd1;
   localparam logic [1:0] PHASE_RACING   = 2'd2;
   localparam logic [1:0] PHASE_FINISHED = 2'd3;

   // Register indexes.
   localparam logic [1:0] CSR_TRACK_LENGTH = 2'd0;
   localparam logic [1:0] CSR_MAX_RACE     = 2'd1;
   localparam logic [1:0] CSR_RESET_DELAY  = 2'd2;

   localparam logic [TrackW-1:0] TRACK_RESET = TrackW'(10000);
   localparam logic [SpanW-1:0]  MAX_RESET   = SpanW'(60000000);
   localparam logic [SpanW-1:0]  DELAY_RESET = SpanW'(5000000);

   typedef struct packed {
      logic [2:0]       mode;
      logic [TimeW-1:0] peer_time_us;
      logic [TimeW-1:0] local_time_us;
   } req_type;

   typedef struct packed {
      logic [1:0]       race_phase;
      logic             result_valid;
      logic [SpanW-1:0] race_time_us;
      logic             timing_error;
      logic [SpanW-1:0] speed_mm_per_s;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic check;
      logic mult;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_check;
      logic fin;
      logic err;
      logic div_last;
   } sts_type;

endpackage
`default_nettype wire

// ----- hdl/rgtu_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgtu_ctrl
// Sequencer of the timing unit: accepts one event, steps the datapath through
// update and, as needed, a time check, numerator product and serial division, then emits.
// ----------------------------------------------------------------------------
module rgtu_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire rgtu_pkg::sts_type sts,
   output rgtu_pkg::cmd_type      cmd
);
   import rgtu_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_CHECK = 6'b000100,
      ST_MULT  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      emit_go;

   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.need_check ? ST_CHECK : ST_EMIT;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = (sts.fin && !sts.err) ? ST_MULT : ST_EMIT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = emit_go;
            if (emit_go) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (emit_go) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted event always enters the update step next.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_EXEC))
      else $error("accepted event did not enter update step");

   // The last division step leads straight to the emit step.
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && sts.div_last) |=> (state_ff == ST_EMIT))
      else $error("division did not end in emit");

   // A full, stalled output register holds the controller in emit.
   a_emit_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_EMIT))
      else $error("emit overwrote a pending result");

   // An emit leaves a valid result and a ready input side.
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("emit did not present a result");

endmodule
`default_nettype wire

// ----- hdl/rgtu_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgtu_dp
// Datapath of the timing unit: race state, configuration registers, the
// elapsed-time checks, the numerator product and a radix-2 restoring divider.
// ----------------------------------------------------------------------------
module rgtu_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rgtu_pkg::req_type            req_data,
   output rgtu_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_we,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [rgtu_pkg::CsrW-1:0]    csr_wdata,
   input  wire rgtu_pkg::cmd_type            cmd,
   output rgtu_pkg::sts_type                 sts
);
   import rgtu_pkg::*;

   // Race state and configuration, reset to defined values.
   logic [1:0]        phase_ff, phase_in;
   logic [TimeW-1:0]  start_ff, start_in;
   logic [TimeW-1:0]  finish_ff, finish_in;
   logic [TimeW-1:0]  offset_ff, offset_in;
   logic              await_ff, await_in;
   logic              fin_ff, fin_in;
   logic              err_ff, err_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [TrackW-1:0] track_ff, track_in;
   logic [SpanW-1:0]  max_ff, max_in;
   logic [SpanW-1:0]  delay_ff, delay_in;

   // Working registers.
   req_type           req_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [TimeW-1:0]  diff_ff, diff_in;
   logic [SpanW-1:0]  rem_ff, rem_in;
   logic [NumW-1:0]   quo_ff, quo_in;

   logic              is_finish, is_tick, fin_hit, tick_hit, range_err, ok;
   logic [SpanW+1:0]  trial;
   logic [SpanW:0]    shifted;
   logic [SpanW-1:0]  speed_sat;

   assign is_finish = (req_ff.mode == MODE_FINISH);
   assign is_tick   = (req_ff.mode == MODE_TICK);
   assign fin_hit   = is_finish && (phase_ff == PHASE_RACING);
   assign tick_hit  = is_tick && await_ff;
   assign range_err = (diff_ff == '0) || diff_ff[TimeW-1]
                      || (diff_ff > {{(TimeW-SpanW){1'b0}}, max_ff});

   assign shifted = {rem_ff, quo_ff[NumW-1]};
   assign trial   = {1'b0, shifted} - {2'b00, diff_ff[SpanW-1:0]};
   assign speed_sat = (|quo_ff[NumW-1:SpanW]) ? '1 : quo_ff[SpanW-1:0];
   assign ok      = fin_ff && !err_ff;

   assign sts.need_check = fin_hit || tick_hit;
   assign sts.fin        = fin_ff;
   assign sts.err        = range_err;
   assign sts.div_last   = (cnt_ff == CntW'(DivSteps - 1));

   assign rsp_data = rsp_ff;

   always_comb begin
      phase_in  = phase_ff;
      start_in  = start_ff;
      finish_in = finish_ff;
      offset_in = offset_ff;
      await_in  = await_ff;
      fin_in    = fin_ff;
      err_in    = err_ff;
      cnt_in    = cnt_ff;
      track_in  = track_ff;
      max_in    = max_ff;
      delay_in  = delay_ff;
      diff_in   = diff_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      rsp_in    = rsp_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_TRACK_LENGTH: track_in = csr_wdata[TrackW-1:0];
            CSR_MAX_RACE:     max_in   = csr_wdata[SpanW-1:0];
            CSR_RESET_DELAY:  delay_in = csr_wdata[SpanW-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.exec) begin
         fin_in  = fin_hit;
         err_in  = 1'b0;
         diff_in = req_ff.local_time_us - (is_finish ? start_ff : finish_ff);
         case (req_ff.mode)
            MODE_ARM: begin
               if (phase_ff == PHASE_IDLE) phase_in = PHASE_ARMED;
            end
            MODE_START: begin
               if (phase_ff == PHASE_ARMED) begin
                  start_in = req_ff.peer_time_us - offset_ff;
                  phase_in = PHASE_RACING;
               end
            end
            MODE_OFFSET: begin
               offset_in = req_ff.peer_time_us - req_ff.local_time_us;
            end
            MODE_FINISH: begin
               if (fin_hit) begin
                  finish_in = req_ff.local_time_us;
                  phase_in  = PHASE_FINISHED;
                  await_in  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.check) begin
         if (fin_ff) begin
            err_in = range_err;
         end else if (diff_ff > {{(TimeW-SpanW){1'b0}}, delay_ff}) begin
            await_in  = 1'b0;
            phase_in  = PHASE_IDLE;
            start_in  = '0;
            finish_in = '0;
         end
      end

      if (cmd.mult) begin
         quo_in = NumW'(track_ff) * NumW'(US_PER_S);
         rem_in = '0;
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         if (trial[SpanW+1]) begin
            rem_in = shifted[SpanW-1:0];
         end else begin
            rem_in = trial[SpanW-1:0];
         end
         quo_in = {quo_ff[NumW-2:0], ~trial[SpanW+1]};
         cnt_in = cnt_ff + CntW'(1);
      end

      if (cmd.emit) begin
         rsp_in.race_phase     = phase_ff;
         rsp_in.result_valid   = fin_ff;
         rsp_in.race_time_us   = ok ? diff_ff[SpanW-1:0] : '0;
         rsp_in.timing_error   = fin_ff && err_ff;
         rsp_in.speed_mm_per_s = ok ? speed_sat : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_IDLE;
         start_ff  <= '0;
         finish_ff <= '0;
         offset_ff <= '0;
         await_ff  <= 1'b0;
         fin_ff    <= 1'b0;
         err_ff    <= 1'b0;
         cnt_ff    <= '0;
         track_ff  <= TRACK_RESET;
         max_ff    <= MAX_RESET;
         delay_ff  <= DELAY_RESET;
      end else begin
         phase_ff  <= phase_in;
         start_ff  <= start_in;
         finish_ff <= finish_in;
         offset_ff <= offset_in;
         await_ff  <= await_in;
         fin_ff    <= fin_in;
         err_ff    <= err_in;
         cnt_ff    <= cnt_in;
         track_ff  <= track_in;
         max_ff    <= max_in;
         delay_ff  <= delay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      diff_ff <= diff_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      rsp_ff  <= rsp_in;
   end

   // The wait for the reset delay exists exactly while a race is finished.
   a_await_phase: assert property (@(posedge clock) disable iff (reset)
      await_ff == (phase_ff == PHASE_FINISHED))
      else $error("awaiting flag out of step with phase");

endmodule
`default_nettype wire

// ----- hdl/race_gate_timing_unit_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// race_gate_timing_unit_top
// Finish-gate race timer that works across the start gate's clock and the
// local clock, reporting elapsed time and average speed.
// ----------------------------------------------------------------------------
// Usage:
// Each event (arm, start message, offset reply, finish edge, tick) is one
// transfer on the req_ channel; each event gives exactly one transfer on the
// rsp_ channel carrying the phase after the event and, for the finish edge
// that ends a race, the elapsed time, error flag and speed.
// Most events pass the update step, then emit; a tick while a finished race
// waits adds the reset-delay check, and a race-ending finish edge adds the
// range check and, if in range, the numerator product and a 36-step radix-2
// divider that forms the speed one quotient bit per cycle. One event is worked
// on at a time; req_ready is high only while the unit is between events.
// The result sits in an output register: a stalled receiver does not block
// the next input transfer, but the unit holds in its emit step until that
// register is free. A synchronous reset clears the race state to idle, the
// clock offset to zero and the registers to their defaults. Configuration
// writes through csr_ are taken in any cycle and are meant for idle periods.
// ----------------------------------------------------------------------------
module race_gate_timing_unit_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire rgtu_pkg::req_type         req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rgtu_pkg::rsp_type              rsp_data,
   input  wire logic                      csr_we,
   input  wire logic [1:0]                csr_index,
   input  wire logic [rgtu_pkg::CsrW-1:0] csr_wdata
);
   import rgtu_pkg::*;

   // Commands from the sequencer and status back from the datapath.
   cmd_type cmd;
   sts_type sts;

   // The sequencer owns the handshakes and the output-register valid flag.
   rgtu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the race state, registers, divider and result payload.
   rgtu_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
`default_nettype wire
